// File: hdl/shf_pkg.sv
`timescale 1ns / 1ps
// Package for the sync-header frame receiver: sizes, sync bytes, reset
// values of the payload store and the structs passed between modules.
// No dependencies.
package shf_pkg;

    localparam int PAYLOAD_LEN = 7;
    localparam int SHOWN_BYTES = 7;
    localparam int CNT_W       = $clog2(PAYLOAD_LEN + 1);
    localparam int IDX_W       = $clog2(SHOWN_BYTES);

    localparam logic [7:0] SYNC_A = 8'hFF;
    localparam logic [7:0] SYNC_B = 8'hFE;
    localparam logic [7:0] SYNC_C = 8'hFD;

    typedef logic [SHOWN_BYTES-1:0][7:0] payload_t;

    typedef struct packed {
        logic     frame_done;
        payload_t payload;
    } result_t;

    typedef struct packed {
        logic             capturing;
        logic [CNT_W-1:0] count;
    } status_t;

    // Reset contents of the payload store, entry 0 in the low byte.
    function automatic payload_t store_init();
        payload_t p;
        p = '0;
        p[3] = 8'd16;
        p[4] = 8'd88;
        p[5] = 8'd18;
        return p;
    endfunction

endpackage

// File: hdl/shf_core.sv
`timescale 1ns / 1ps
// Frame state of the receiver: byte history, capture flag, byte count and
// payload store, updated once per item. Depends on shf_pkg.
module shf_core
    import shf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] rx_byte,
    output result_t    res_next,
    output status_t    status
);

    logic [7:0]       hist1_reg, hist2_reg;
    logic             capt_reg, capt_next;
    logic [CNT_W-1:0] count_reg, count_next;
    payload_t         store_reg, store_next;
    logic             header_hit;
    logic             done;
    logic [IDX_W-1:0] wr_idx;
    logic             wr_en;

    assign wr_idx = IDX_W'(count_reg);
    assign wr_en  = capt_reg && (32'(count_reg) < 32'(PAYLOAD_LEN))
                    && (32'(count_reg) < 32'(SHOWN_BYTES));
    // history after the shift: old hist1, old hist2, new byte
    assign header_hit = (hist1_reg == SYNC_A) && (hist2_reg == SYNC_B)
                        && (rx_byte == SYNC_C);

    always_comb
    begin
        store_next = store_reg;
        for (int k = 0; k < SHOWN_BYTES; k++)
        begin
            if (wr_en && (wr_idx == IDX_W'(k)))
            begin
                store_next[k] = rx_byte;
            end
        end

        capt_next  = capt_reg;
        count_next = capt_reg ? count_reg + 1'b1 : count_reg;
        if (header_hit)
        begin
            capt_next  = 1'b1;
            count_next = '0;
        end
        done = (32'(count_next) >= 32'(PAYLOAD_LEN));
        if (done)
        begin
            capt_next  = 1'b0;
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist1_reg <= '0;
            hist2_reg <= '0;
            capt_reg  <= 1'b0;
            count_reg <= '0;
            store_reg <= store_init();
        end
        else if (step)
        begin
            hist1_reg <= hist2_reg;
            hist2_reg <= rx_byte;
            capt_reg  <= capt_next;
            count_reg <= count_next;
            store_reg <= store_next;
        end
    end

    assign res_next.frame_done = done;
    assign res_next.payload    = store_next;
    assign status.capturing    = capt_reg;
    assign status.count        = count_reg;

endmodule

// File: hdl/shf_out_reg.sv
`timescale 1ns / 1ps
// Result register of the receiver: holds one result until the sink takes it.
// Depends on shf_pkg.
module shf_out_reg
    import shf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  logic    take,
    input  result_t res_d,
    output logic    valid,
    output result_t res_q
);

    logic    valid_reg, valid_next;
    result_t res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_d;
        end
    end

    assign valid = valid_reg;
    assign res_q = res_reg;

endmodule

// File: hdl/sync_header_frame_receiver_unit.sv
`timescale 1ns / 1ps
// Sync-header frame receiver, top level. Uses shf_pkg, shf_core, shf_out_reg.
// An accepted item waits in the input register, which feeds the result register
// directly through shf_core. Throughput: 1 item per cycle while the sink takes
// results. Reset (async, active low) clears history, capture flag, count and
// valid bits and loads the payload store with its default.
module sync_header_frame_receiver_unit
    import shf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       frame_done,
    output logic [7:0] payload_b0,
    output logic [7:0] payload_b1,
    output logic [7:0] payload_b2,
    output logic [7:0] payload_b3,
    output logic [7:0] payload_b4,
    output logic [7:0] payload_b5,
    output logic [7:0] payload_b6
);

    logic       in_valid_reg;
    logic [7:0] rx_reg;
    logic       advance;
    result_t    res_next;
    result_t    res_q;
    status_t    status;

    // Advance the held item into the frame logic whenever the result register
    // is empty or its contents are being taken this cycle.
    assign advance  = in_valid_reg && (!out_valid || out_ready);
    // Accept a new item when the input register is empty or drains now.
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            rx_reg <= rx_byte;
        end
    end

    // Header detection, capture and payload store; result reflects the store
    // after this item's update, and frame_done flags frame completion.
    shf_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .rx_byte  (rx_reg),
        .res_next (res_next),
        .status   (status)
    );

    shf_out_reg u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (advance),
        .take  (out_ready),
        .res_d (res_next),
        .valid (out_valid),
        .res_q (res_q)
    );

    assign frame_done = res_q.frame_done;
    assign payload_b0 = res_q.payload[0];
    assign payload_b1 = res_q.payload[1];
    assign payload_b2 = res_q.payload[2];
    assign payload_b3 = res_q.payload[3];
    assign payload_b4 = res_q.payload[4];
    assign payload_b5 = res_q.payload[5];
    assign payload_b6 = res_q.payload[6];

    // Count stays inside the payload range between items.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(status.count) < 32'(PAYLOAD_LEN))
        else $error("byte count out of range");

    // An idle receiver has a cleared count.
    a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        !status.capturing |-> (status.count == '0))
        else $error("count nonzero while not capturing");

    // A completed frame disarms capture.
    a_done_disarm: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res_next.frame_done) |=> !status.capturing)
        else $error("capture still armed after frame completion");

    // An empty result register never blocks the input side.
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result register");

endmodule

// File: tb/tb_sync_header_frame_receiver_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for sync_header_frame_receiver_unit. Depends on shf_pkg and the
// unit itself; feeds byte streams built from sync headers, payloads and noise, and checks
// every result against an in-bench model of the deframer.
module tb_sync_header_frame_receiver_unit;
    import shf_pkg::*;

    localparam int HOLD_CYCLES = 400;   // length of the long receiver hold-off
    localparam int MAX_REPORTS = 100;   // cap on printed mismatch lines
    localparam int DRAIN_CYCLES = 10;   // idle time after the final drain

    // Default contents of the payload store, entry 0 in the low byte.
    localparam bit [SHOWN_BYTES-1:0][7:0] STORE_DEFAULT =
        {8'd0, 8'd18, 8'd88, 8'd16, 8'd0, 8'd0, 8'd0};

    typedef struct packed {
        bit                          done;
        bit [SHOWN_BYTES-1:0][7:0]   bytes;
    } frame_view_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [7:0] rx_byte   = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       frame_done;
    logic [7:0] payload_b0, payload_b1, payload_b2, payload_b3;
    logic [7:0] payload_b4, payload_b5, payload_b6;

    // Bytes waiting to be offered and results still owed by the unit.
    logic [7:0]  rx_pending [$];
    frame_view_t expected_frames [$];

    // Deframer model state.
    bit [7:0]                  sync_window [3];
    bit                        capture_on;
    int                        capture_idx;
    bit [SHOWN_BYTES-1:0][7:0] shown_store;

    // Idling controls; the sequencer changes its settings on falling edges only.
    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;
    int hold_cnt = 0;
    wire hold_active = hold_req && !hold_done;

    int n_queued = 0;
    int n_accepted = 0;
    int n_results = 0;
    int n_frames = 0;
    int n_input_stalls = 0;
    int n_errors = 0;

    sync_header_frame_receiver_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .frame_done (frame_done),
        .payload_b0 (payload_b0),
        .payload_b1 (payload_b1),
        .payload_b2 (payload_b2),
        .payload_b3 (payload_b3),
        .payload_b4 (payload_b4),
        .payload_b5 (payload_b5),
        .payload_b6 (payload_b6)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop in case the unit hangs.
    initial
    begin
        #2_000_000;
        $display("tb_sync_header_frame_receiver_unit: errors");
        $finish;
    end

    // Advance the deframer by one byte and record the result it owes.
    // Order matters: shift the window, store while capturing, then look for
    // the header, and check for a full payload last.
    function automatic void advance_deframer(input bit [7:0] b);
        frame_view_t r;
        sync_window[0] = sync_window[1];
        sync_window[1] = sync_window[2];
        sync_window[2] = b;
        if (capture_on)
        begin
            // Bytes past the shown entries are not stored.
            if (capture_idx < PAYLOAD_LEN && capture_idx < SHOWN_BYTES)
                shown_store[capture_idx] = b;
            capture_idx++;
        end
        // A header restarts the frame, even halfway through a payload.
        if (sync_window[0] == SYNC_A && sync_window[1] == SYNC_B && sync_window[2] == SYNC_C)
        begin
            capture_idx = 0;
            capture_on = 1'b1;
        end
        r.done = 1'b0;
        if (capture_idx >= PAYLOAD_LEN)
        begin
            capture_on = 1'b0;
            capture_idx = 0;
            r.done = 1'b1;
            n_frames++;
        end
        r.bytes = shown_store;
        expected_frames.push_back(r);
    endfunction

    task automatic report_field(input string what, input logic [7:0] want,
                                input logic [7:0] got);
        if (want !== got)
        begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    // Sender: offer the next pending byte unless idling; hold the byte while
    // the unit stalls. Feed every accepted byte to the model.
    always @(posedge clk)
    begin : drive_proc
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                advance_deframer(rx_byte);
                n_accepted++;
            end
            if (in_valid && !in_ready)
                n_input_stalls++;
            if (!in_valid || in_ready)
            begin
                if (rx_pending.size() > 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    in_valid <= 1'b1;
                    rx_byte  <= rx_pending.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: take results, compare each with the oldest owed one, and pick
    // the next ready at random unless a long hold-off is running.
    always @(posedge clk)
    begin : check_proc
        frame_view_t               want;
        bit [SHOWN_BYTES-1:0][7:0] got_bytes;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                n_results++;
                if (expected_frames.size() == 0)
                begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("%0t: result with none owed, frame_done %0d", $time, frame_done);
                end
                else
                begin
                    want = expected_frames.pop_front();
                    got_bytes = {payload_b6, payload_b5, payload_b4, payload_b3,
                                 payload_b2, payload_b1, payload_b0};
                    report_field("frame_done", {7'd0, want.done}, {7'd0, frame_done});
                    for (int k = 0; k < SHOWN_BYTES; k++)
                        report_field($sformatf("payload_b%0d", k), want.bytes[k], got_bytes[k]);
                end
            end
            out_ready <= !hold_active && ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Long hold-off: count cycles here, independent of traffic.
    always @(posedge clk)
    begin
        if (hold_active)
        begin
            if (hold_cnt == HOLD_CYCLES - 1)
                hold_done <= 1'b1;
            hold_cnt <= hold_cnt + 1;
        end
    end

    task automatic push_byte(input bit [7:0] b);
        rx_pending.push_back(b);
        n_queued++;
    endtask

    task automatic push_header();
        push_byte(SYNC_A);
        push_byte(SYNC_B);
        push_byte(SYNC_C);
    endtask

    // Random byte, optionally leaning toward sync values to form near-headers.
    function automatic bit [7:0] pick_byte(input bit lean_sync);
        int r;
        r = $urandom_range(5);
        if (lean_sync && r == 0)
            return SYNC_A;
        if (lean_sync && r == 1)
            return SYNC_B;
        if (lean_sync && r == 2)
            return SYNC_C;
        return 8'($urandom_range(255));
    endfunction

    // Queue a mix dominated by well-formed frames, with truncated frames,
    // headers inside payloads and loose noise making up the rest.
    task automatic queue_traffic(input int count);
        int goal;
        int kind;
        int len;
        goal = n_queued + count;
        while (n_queued < goal)
        begin
            kind = $urandom_range(99);
            if (kind < 60)
            begin
                push_header();
                repeat (PAYLOAD_LEN) push_byte(pick_byte(1'b0));
            end
            else if (kind < 72)
            begin
                push_header();
                repeat (PAYLOAD_LEN) push_byte(pick_byte(1'b1));
            end
            else if (kind < 82)
            begin
                push_header();
                len = $urandom_range(PAYLOAD_LEN - 1);
                repeat (len) push_byte(pick_byte(1'b0));
            end
            else if (kind < 90)
            begin
                push_header();
                len = $urandom_range(PAYLOAD_LEN - 1);
                repeat (len) push_byte(pick_byte(1'b0));
                push_header();
                repeat (PAYLOAD_LEN) push_byte(pick_byte(1'b0));
            end
            else
            begin
                len = $urandom_range(6, 1);
                repeat (len) push_byte(pick_byte(1'b1));
            end
        end
    endtask

    // Wait until every queued byte is taken and every owed result is in.
    task automatic wait_drained();
        while (rx_pending.size() > 0 || in_valid || expected_frames.size() > 0)
            @(negedge clk);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
        @(negedge clk);
        src_idle_pct  = idle_pct;
        snk_stall_pct = stall_pct;
        queue_traffic(count);
        wait_drained();
    endtask

    // Sequencer: reset, directed bytes, then random phases with different
    // idling, then the long hold-off, then the final drain.
    initial
    begin : sequencer
        bit [7:0] directed [] = '{
            // FE FD right after reset: the zero history must not complete a header
            8'hFE, 8'hFD,
            // Plain frame with extreme values and sync bytes out of order
            8'hFF, 8'hFE, 8'hFD, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'hFD,
            // Header inside a payload: FD is stored, then the count restarts
            8'hFF, 8'hFE, 8'hFD, 8'h55, 8'hFF, 8'hFE, 8'hFD,
            8'hAA, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20
        };

        sync_window = '{default: 8'h00};
        capture_on  = 1'b0;
        capture_idx = 0;
        shown_store = STORE_DEFAULT;

        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[i])
            push_byte(directed[i]);
        wait_drained();

        run_phase(0, 0, 330);
        run_phase(59, 0, 330);
        run_phase(0, 59, 330);
        run_phase(13, 13, 330);

        // Hold the receiver off while the sender streams, so the unit fills
        // and pushes back on its input.
        @(negedge clk);
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        hold_req      = 1'b1;
        queue_traffic(120);
        while (!hold_done)
            @(negedge clk);
        wait_drained();

        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d bytes and checked %0d results, %0d of them completed frames.",
                 n_accepted, n_results, n_frames);
        $display("Input was held off for %0d cycles; %0d mismatches found.",
                 n_input_stalls, n_errors);
        if (n_errors == 0 && expected_frames.size() == 0)
            $display("tb_sync_header_frame_receiver_unit: clean");
        else
            $display("tb_sync_header_frame_receiver_unit: errors");
        $finish;
    end

endmodule
